@@ hw/rtl/rlwd_pkg.sv @@
// ----------------------------------------------------------------------------
// rlwd_pkg
// Types and constants shared by the run-length decoder with a Wyle-coded
// length field.
// ----------------------------------------------------------------------------
package rlwd_pkg;

    // Widest supported length field, in bits.
    localparam int MAX_LENGTH_BITS = 24;

    localparam int BYTE_W     = 8;
    localparam int SIZE_W     = 32;
    localparam int HDR_BYTES  = 4;
    localparam int HCNT_W     = 3;
    localparam int SBITS_W    = 4;
    localparam int OUT_LEN_W  = 25;
    localparam int PROD_W     = SIZE_W + 1;
    localparam int ONES_W     = $clog2(MAX_LENGTH_BITS);
    localparam int VBITS_W    = $clog2(MAX_LENGTH_BITS + 1);
    localparam int LEN_W      = MAX_LENGTH_BITS + 1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_UNARY,
        PH_VALUE,
        PH_SYMBOL
    } t_phase;

    // What the parser hands on for one beat.
    typedef struct packed {
        logic                 restart;
        logic                 has_run;
        logic                 has_err;
        logic [BYTE_W-1:0]    symbol;
        logic [LEN_W-1:0]     length;
        logic [SIZE_W-1:0]    total;
    } t_run_info;

endpackage

@@ hw/rtl/rlwd_parser.sv @@
// ----------------------------------------------------------------------------
// rlwd_parser
// Header capture and bit-level parsing of one compressed byte per step:
// unary width prefix, value field and symbol, with an error on a width that
// exceeds the supported bound.
// ----------------------------------------------------------------------------
module rlwd_parser
    import rlwd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_byte,
    input  logic            i_restart,
    output t_run_info       o_info
);

    t_phase                     r_phase,   n_phase;
    logic [HCNT_W-1:0]          r_hcnt,    n_hcnt;
    logic [SIZE_W-1:0]          r_total,   n_total;
    logic [ONES_W-1:0]          r_ones,    n_ones;
    logic [VBITS_W-1:0]         r_vbits,   n_vbits;
    logic [MAX_LENGTH_BITS-1:0] r_vacc,    n_vacc;
    logic [BYTE_W-1:0]          r_sacc,    n_sacc;
    logic [SBITS_W-1:0]         r_sbits,   n_sbits;
    logic                       r_halted,  n_halted;

    function automatic logic width_too_big(t_phase ph, logic [ONES_W-1:0] ones);
        return (ph == PH_UNARY) && (ones >= ONES_W'(MAX_LENGTH_BITS - 1));
    endfunction

    always_comb begin
        logic                  bitv;
        logic                  run_found;
        logic [BYTE_W-1:0]     run_sym;
        logic [LEN_W-1:0]      run_len;
        logic [VBITS_W:0]      seen_next;
        logic [VBITS_W:0]      width;
        logic                  err;

        run_found = 1'b0;
        run_sym   = '0;
        run_len   = '0;
        err       = 1'b0;
        bitv      = 1'b0;
        seen_next = '0;
        width     = '0;

        if (i_restart) begin
            n_phase  = PH_HEADER;
            n_hcnt   = '0;
            n_total  = '0;
            n_ones   = '0;
            n_vbits  = '0;
            n_vacc   = '0;
            n_sacc   = '0;
            n_sbits  = '0;
            n_halted = 1'b0;
        end else begin
            n_phase  = r_phase;
            n_hcnt   = r_hcnt;
            n_total  = r_total;
            n_ones   = r_ones;
            n_vbits  = r_vbits;
            n_vacc   = r_vacc;
            n_sacc   = r_sacc;
            n_sbits  = r_sbits;
            n_halted = r_halted;
        end

        if (!n_halted) begin
            if (n_phase == PH_HEADER) begin
                n_total = {n_total[SIZE_W-BYTE_W-1:0], i_byte};
                n_hcnt  = n_hcnt + HCNT_W'(1);
                if (n_hcnt >= HCNT_W'(HDR_BYTES)) begin
                    n_phase = PH_UNARY;
                    if (n_total == '0) begin
                        n_halted = 1'b1;
                    end
                end
            end else begin
                // Bits are taken most significant first; reading stops as
                // soon as the prefix has grown beyond the supported width.
                for (int b = 7; b >= 0; b--) begin
                    bitv = i_byte[b];
                    if (!width_too_big(n_phase, n_ones)) begin
                        unique case (n_phase)
                            PH_UNARY: begin
                                if (bitv) begin
                                    n_ones = n_ones + ONES_W'(1);
                                end else begin
                                    n_phase = PH_VALUE;
                                    n_vbits = '0;
                                    n_vacc  = '0;
                                end
                            end
                            PH_VALUE: begin
                                for (int j = 0; j < MAX_LENGTH_BITS; j++) begin
                                    if (n_vbits == VBITS_W'(j)) begin
                                        n_vacc[j] = bitv;
                                    end
                                end
                                seen_next = (VBITS_W+1)'(n_vbits) + (VBITS_W+1)'(1);
                                width     = (VBITS_W+1)'(n_ones) + (VBITS_W+1)'(2);
                                n_vbits   = n_vbits + VBITS_W'(1);
                                if (seen_next >= width) begin
                                    n_phase = PH_SYMBOL;
                                    n_sbits = '0;
                                    n_sacc  = '0;
                                end
                            end
                            PH_SYMBOL: begin
                                n_sacc  = {n_sacc[BYTE_W-2:0], bitv};
                                n_sbits = n_sbits + SBITS_W'(1);
                                if (n_sbits >= SBITS_W'(BYTE_W)) begin
                                    run_found = 1'b1;
                                    run_sym   = n_sacc;
                                    run_len   = LEN_W'(n_vacc) + LEN_W'(1);
                                    n_phase   = PH_UNARY;
                                    n_ones    = '0;
                                    n_vbits   = '0;
                                    n_vacc    = '0;
                                    n_sbits   = '0;
                                    n_sacc    = '0;
                                end
                            end
                            default: begin
                                n_phase = PH_UNARY;
                            end
                        endcase
                    end
                end
                // An error found in a byte that already closed a run is
                // reported with the following beat.
                if (!run_found && width_too_big(n_phase, n_ones)) begin
                    err      = 1'b1;
                    n_halted = 1'b1;
                end
            end
        end

        o_info.restart = i_restart;
        o_info.has_run = run_found;
        o_info.has_err = err;
        o_info.symbol  = run_sym;
        o_info.length  = run_len;
        o_info.total   = n_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_hcnt   <= '0;
            r_total  <= '0;
            r_ones   <= '0;
            r_vbits  <= '0;
            r_vacc   <= '0;
            r_sacc   <= '0;
            r_sbits  <= '0;
            r_halted <= 1'b0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_hcnt   <= n_hcnt;
            r_total  <= n_total;
            r_ones   <= n_ones;
            r_vbits  <= n_vbits;
            r_vacc   <= n_vacc;
            r_sacc   <= n_sacc;
            r_sbits  <= n_sbits;
            r_halted <= n_halted;
        end
    end

    a_halted_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_halted && !i_restart) |-> !(o_info.has_run || o_info.has_err))
        else $error("parser produced a result while halted");

    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_info.has_err) |=> r_halted)
        else $error("parser did not halt after a width error");

endmodule

@@ hw/rtl/run_length_wyle_decoder.sv @@
// Path: input register, run register, result register, in that order; at
// most one run result per byte. A stalled output holds back the stream.
// Throughput: one compressed byte per cycle while the output is not stalled.
// Reset: synchronous, active low; clears all stream state to the header phase.
// ----------------------------------------------------------------------------
// run_length_wyle_decoder
// Decodes a run-length stream whose run lengths use a Wyle-style code and
// emits one symbol/length pair per run, flagging the run that completes the
// decoded size given in the four-byte header.
// ----------------------------------------------------------------------------
module run_length_wyle_decoder
    import rlwd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [7:0]              i_stream_byte,
    input  logic                    i_restart,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [7:0]              o_run_symbol,
    output logic [OUT_LEN_W-1:0]    o_run_length,
    output logic                    o_last,
    output logic                    o_error
);

    logic                   r_in_vld;
    logic [7:0]             r_in_byte;
    logic                   r_in_restart;

    logic                   r_run_vld;
    t_run_info              r_run;
    t_run_info              parse_info;

    logic                   r_out_vld;
    logic [7:0]             r_out_sym;
    logic [OUT_LEN_W-1:0]   r_out_len;
    logic                   r_out_last;
    logic                   r_out_err;

    logic [PROD_W-1:0]      r_produced, n_produced;
    logic                   r_done,     n_done;

    logic                   out_en;
    logic                   run_free;
    logic                   step;

    logic                   n_emit;
    logic [7:0]             n_sym;
    logic [OUT_LEN_W-1:0]   n_len;
    logic                   n_last;
    logic                   n_err;
    logic [PROD_W-1:0]      sum;

    assign out_en     = !r_out_vld || i_out_ready;
    assign run_free   = !r_run_vld || out_en;
    assign step       = r_in_vld && run_free;
    assign o_in_ready = !r_in_vld || run_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte    <= i_stream_byte;
            r_in_restart <= i_restart;
        end
    end

    rlwd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_byte    (r_in_byte),
        .i_restart (r_in_restart),
        .o_info    (parse_info)
    );

    // Only beats that start a stream or carry a result travel on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_vld <= 1'b0;
        end else if (run_free) begin
            r_run_vld <= step && (parse_info.restart || parse_info.has_run ||
                                  parse_info.has_err);
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_run <= parse_info;
        end
    end

    // Running total of decoded bytes; results after the final run are dropped.
    always_comb begin
        logic [PROD_W-1:0] prod_base;
        logic              done_base;

        prod_base  = r_run.restart ? '0 : r_produced;
        done_base  = r_run.restart ? 1'b0 : r_done;
        sum        = prod_base + PROD_W'(r_run.length);
        n_emit     = 1'b0;
        n_sym      = '0;
        n_len      = '0;
        n_last     = 1'b0;
        n_err      = 1'b0;
        n_produced = prod_base;
        n_done     = done_base;

        if (r_run_vld && !done_base) begin
            priority if (r_run.has_err) begin
                n_emit = 1'b1;
                n_last = 1'b1;
                n_err  = 1'b1;
                n_done = 1'b1;
            end else if (r_run.has_run) begin
                n_emit     = 1'b1;
                n_sym      = r_run.symbol;
                n_len      = OUT_LEN_W'(r_run.length);
                n_last     = sum >= PROD_W'(r_run.total);
                n_produced = sum;
                n_done     = n_last;
            end else begin
                // A beat that only starts a stream clears the total and
                // gives no result.
                n_emit = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_produced <= '0;
            r_done     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (r_run_vld && out_en) begin
                r_produced <= n_produced;
                r_done     <= n_done;
            end
            if (out_en) begin
                r_out_vld <= n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && n_emit) begin
            r_out_sym  <= n_sym;
            r_out_len  <= n_len;
            r_out_last <= n_last;
            r_out_err  <= n_err;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_run_symbol = r_out_sym;
    assign o_run_length = r_out_len;
    assign o_last       = r_out_last;
    assign o_error      = r_out_err;

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |-> (o_last && o_run_length == '0 && o_run_symbol == '0))
        else $error("error result is not a final empty beat");

    a_quiet_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_vld && out_en && r_done && !r_run.restart) |=> !o_out_valid)
        else $error("result emitted after the stream was complete");

    a_last_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_en && n_emit && n_last) |=> r_done)
        else $error("final beat did not close the stream");

endmodule
